/* rtl/ctgu_pkg.sv */
// Shared opcodes and field widths for the Clifford tableau gate update block.
package ctgu_pkg;

  localparam int unsigned OP_W     = 4;
  localparam int unsigned QUBIT_W  = 4;
  localparam int unsigned COLUMN_W = 5;
  localparam int unsigned RD_W     = 16;

  localparam logic [OP_W-1:0] OP_X    = 4'd0;
  localparam logic [OP_W-1:0] OP_Z    = 4'd1;
  localparam logic [OP_W-1:0] OP_S    = 4'd2;
  localparam logic [OP_W-1:0] OP_SDG  = 4'd3;
  localparam logic [OP_W-1:0] OP_H    = 4'd4;
  localparam logic [OP_W-1:0] OP_V    = 4'd5;
  localparam logic [OP_W-1:0] OP_CX   = 4'd6;
  localparam logic [OP_W-1:0] OP_CZ   = 4'd7;
  localparam logic [OP_W-1:0] OP_SWAP = 4'd8;
  localparam logic [OP_W-1:0] OP_READ = 4'd9;

endpackage

/* rtl/clifford_tableau_gate_update.sv */
// Path: an accepted request is held in the input register, then in the result register, which drives the result port.
// Throughput: one request per cycle; the input register and the result
// register advance together whenever the result register is empty or drained.
// The gate logic on two row pairs and the sign word sets the cycle.
// Reset (rst_n low, synchronous): tableau back to identity, signs cleared,
// both pipeline registers emptied.
module clifford_tableau_gate_update #(
  parameter int unsigned NUM_QUBITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] qubit_a, [7:4] qubit_b, [12:8] column, zero fill
  input  logic [3:0]  in_tuser,   // [3:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] z_column, [31:16] x_column, [32] sign, zero fill
  output logic [0:0]  out_tuser   // [0] error
);

  localparam int unsigned ROW_W = 2 * NUM_QUBITS;
  localparam int unsigned COL_W = $clog2(ROW_W);
  localparam int unsigned Q_W   = $clog2(NUM_QUBITS);
  localparam int unsigned RD_Q  = (NUM_QUBITS < ctgu_pkg::RD_W) ? NUM_QUBITS : ctgu_pkg::RD_W;

  logic [ROW_W-1:0] z_rows_r [NUM_QUBITS];
  logic [ROW_W-1:0] x_rows_r [NUM_QUBITS];
  logic [ROW_W-1:0] sign_r;

  logic                          s1_v_r;
  logic [ctgu_pkg::OP_W-1:0]     s1_op_r;
  logic [ctgu_pkg::QUBIT_W-1:0]  s1_a_r;
  logic [ctgu_pkg::QUBIT_W-1:0]  s1_b_r;
  logic [ctgu_pkg::COLUMN_W-1:0] s1_col_r;

  logic        out_v_r;
  logic [15:0] out_z_r;
  logic [15:0] out_x_r;
  logic        out_s_r;
  logic        out_err_r;

  logic advance;
  logic in_fire;

  logic [5:0]       a_ext;
  logic [5:0]       b_ext;
  logic [6:0]       col_ext;
  logic [Q_W-1:0]   a_idx;
  logic [Q_W-1:0]   b_idx;
  logic [COL_W-1:0] col_idx;
  logic             a_ok;
  logic             b_ok;
  logic             col_ok;

  logic [ROW_W-1:0] za;
  logic [ROW_W-1:0] xa;
  logic [ROW_W-1:0] zb;
  logic [ROW_W-1:0] xb;
  logic [ROW_W-1:0] s;
  logic             we_a;
  logic             we_b;
  logic             err_c;
  logic             rd_c;
  logic [15:0]      rd_z;
  logic [15:0]      rd_x;
  logic             rd_s;

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign a_ext   = {2'b00, s1_a_r};
  assign b_ext   = {2'b00, s1_b_r};
  assign col_ext = {2'b00, s1_col_r};
  assign a_idx   = a_ext[Q_W-1:0];
  assign b_idx   = b_ext[Q_W-1:0];
  assign col_idx = col_ext[COL_W-1:0];
  assign a_ok    = a_ext < 6'(NUM_QUBITS);
  assign b_ok    = b_ext < 6'(NUM_QUBITS);
  assign col_ok  = col_ext < 7'(ROW_W);

  // Gate logic: every column at once, multi-step gates chained in order.
  always_comb begin
    za    = z_rows_r[a_idx];
    xa    = x_rows_r[a_idx];
    zb    = z_rows_r[b_idx];
    xb    = x_rows_r[b_idx];
    s     = sign_r;
    we_a  = 1'b0;
    we_b  = 1'b0;
    err_c = 1'b0;
    rd_c  = 1'b0;
    case (s1_op_r)
      ctgu_pkg::OP_X: begin
        if (a_ok) s = s ^ za;
      end
      ctgu_pkg::OP_Z: begin
        if (a_ok) s = s ^ xa;
      end
      ctgu_pkg::OP_S: begin
        if (a_ok) begin
          s    = s ^ (za & xa);
          za   = za ^ xa;
          we_a = 1'b1;
        end
      end
      ctgu_pkg::OP_SDG: begin
        // three S steps fold to one update
        if (a_ok) begin
          s    = s ^ (~za & xa);
          za   = za ^ xa;
          we_a = 1'b1;
        end
      end
      ctgu_pkg::OP_H: begin
        if (a_ok) begin
          s    = s ^ (xa & za);
          za   = x_rows_r[a_idx];
          xa   = z_rows_r[a_idx];
          we_a = 1'b1;
        end
      end
      ctgu_pkg::OP_V: begin
        if (a_ok) begin
          s    = s ^ (~xa & za);
          xa   = xa ^ za;
          we_a = 1'b1;
        end
      end
      ctgu_pkg::OP_CX: begin
        if (s1_a_r == s1_b_r) begin
          err_c = 1'b1;
        end else if (a_ok && b_ok) begin
          s    = s ^ ((~za ^ xb) & zb & xa);
          za   = za ^ zb;
          xb   = xb ^ xa;
          we_a = 1'b1;
          we_b = 1'b1;
        end
      end
      ctgu_pkg::OP_CZ: begin
        if (s1_a_r == s1_b_r) begin
          err_c = 1'b1;
        end else if (a_ok && b_ok) begin
          s    = s ^ (za & xa);
          za   = za ^ xa;
          s    = s ^ (zb & xb);
          zb   = zb ^ xb;
          s    = s ^ ((~za ^ xb) & zb & xa);
          za   = za ^ zb;
          xb   = xb ^ xa;
          s    = s ^ (zb & xb);
          zb   = zb ^ xb;
          s    = s ^ xb;
          s    = s ^ ((~za ^ xb) & zb & xa);
          za   = za ^ zb;
          xb   = xb ^ xa;
          we_a = 1'b1;
          we_b = 1'b1;
        end
      end
      ctgu_pkg::OP_SWAP: begin
        if (s1_a_r == s1_b_r) begin
          err_c = 1'b1;
        end else if (a_ok && b_ok) begin
          s    = s ^ ((~zb ^ xa) & za & xb);
          zb   = zb ^ za;
          xa   = xa ^ xb;
          s    = s ^ ((~za ^ xb) & zb & xa);
          za   = za ^ zb;
          xb   = xb ^ xa;
          s    = s ^ ((~zb ^ xa) & za & xb);
          zb   = zb ^ za;
          xa   = xa ^ xb;
          we_a = 1'b1;
          we_b = 1'b1;
        end
      end
      ctgu_pkg::OP_READ: begin
        rd_c = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Column read: one bit from each of the low qubits.
  always_comb begin
    rd_z = '0;
    rd_x = '0;
    rd_s = 1'b0;
    if (rd_c && col_ok) begin
      for (int i = 0; i < RD_Q; i++) begin
        rd_z[i] = z_rows_r[i][col_idx];
        rd_x[i] = x_rows_r[i][col_idx];
      end
      rd_s = sign_r[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUBITS; q++) begin
        z_rows_r[q] <= ROW_W'(1) << q;
        x_rows_r[q] <= ROW_W'(1) << (q + NUM_QUBITS);
      end
      sign_r <= '0;
    end else if (advance) begin
      if (we_a) begin
        z_rows_r[a_idx] <= za;
        x_rows_r[a_idx] <= xa;
      end
      if (we_b) begin
        z_rows_r[b_idx] <= zb;
        x_rows_r[b_idx] <= xb;
      end
      sign_r <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_tuser;
      s1_a_r   <= in_tdata[3:0];
      s1_b_r   <= in_tdata[7:4];
      s1_col_r <= in_tdata[12:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_z_r   <= rd_z;
      out_x_r   <= rd_x;
      out_s_r   <= rd_s;
      out_err_r <= err_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_s_r, out_x_r, out_z_r};
  assign out_tuser  = out_err_r;

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && err_c) |=> (out_z_r == 16'b0 && out_x_r == 16'b0 && !out_s_r))
    else $error("errored request returned column data");

  a_err_keeps_signs: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && err_c) |=> $stable(sign_r))
    else $error("errored two-qubit gate changed the sign word");

  a_read_keeps_signs: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && rd_c) |=> $stable(sign_r))
    else $error("column read changed the sign word");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled with room in the pipeline");

endmodule

/* bench/clifford_tableau_gate_update_tb.sv */
// Testbench for the Clifford tableau gate update block: tableau predictor and column checks.
`timescale 1ns / 100ps

module clifford_tableau_gate_update_tb;

  localparam int unsigned NUM_Q        = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned SDG_TURNS    = 3;
  localparam logic [ctgu_pkg::OP_W-1:0] OP_SPARE_FIRST = ctgu_pkg::OP_READ + 4'd1;
  localparam logic [ctgu_pkg::OP_W-1:0] OP_SPARE_LAST  = 4'hF;

  typedef struct packed {
    logic [ctgu_pkg::RD_W-1:0] z_col;
    logic [ctgu_pkg::RD_W-1:0] x_col;
    logic                      sign;
    logic                      err;
  } column_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;

  // Predicted tableau
  logic [2*NUM_Q-1:0] tab_z [NUM_Q];
  logic [2*NUM_Q-1:0] tab_x [NUM_Q];
  logic [2*NUM_Q-1:0] tab_sign;

  column_result_t column_q [$];
  column_result_t oldest_column;
  int unsigned    failures      = 0;
  int unsigned    cycle_count   = 0;
  bit             idling_on     = 1'b0;
  int unsigned    hold_request  = 0;
  int unsigned    hold_left     = 0;
  int unsigned    stall_left    = 0;

  clifford_tableau_gate_update #(.NUM_QUBITS(NUM_Q)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[clifford_tableau_gate_update] ERROR");
      $finish;
    end
  end

  // Tableau update rules
  task automatic tab_reset();
    for (int q = 0; q < NUM_Q; q++) begin
      tab_z[q] = '0;
      tab_x[q] = '0;
      tab_z[q][q] = 1'b1;
      tab_x[q][q+NUM_Q] = 1'b1;
    end
    tab_sign = '0;
  endtask

  task automatic tab_s(input int q);
    tab_sign ^= tab_z[q] & tab_x[q];
    tab_z[q] ^= tab_x[q];
  endtask

  task automatic tab_h(input int q);
    logic [2*NUM_Q-1:0] held;
    held = tab_x[q];
    tab_sign ^= tab_x[q] & tab_z[q];
    tab_x[q] = tab_z[q];
    tab_z[q] = held;
  endtask

  task automatic tab_v(input int q);
    tab_sign ^= ~tab_x[q] & tab_z[q];
    tab_x[q] ^= tab_z[q];
  endtask

  task automatic tab_cx(input int c, input int t);
    tab_sign ^= (~tab_z[c] ^ tab_x[t]) & tab_z[t] & tab_x[c];
    tab_z[c] ^= tab_z[t];
    tab_x[t] ^= tab_x[c];
  endtask

  task automatic predict_column(input logic [ctgu_pkg::OP_W-1:0] op,
                                input logic [ctgu_pkg::QUBIT_W-1:0] a,
                                input logic [ctgu_pkg::QUBIT_W-1:0] b,
                                input logic [ctgu_pkg::COLUMN_W-1:0] col,
                                output column_result_t res);
    res = '0;
    if (op >= ctgu_pkg::OP_CX && op <= ctgu_pkg::OP_SWAP) begin
      if (a == b) begin
        res.err = 1'b1;
      end else if (a < NUM_Q && b < NUM_Q) begin
        case (op)
          ctgu_pkg::OP_CX: begin
            tab_cx(a, b);
          end
          ctgu_pkg::OP_CZ: begin
            tab_s(a);
            tab_s(b);
            tab_cx(a, b);
            tab_s(b);
            tab_sign ^= tab_x[b];
            tab_cx(a, b);
          end
          default: begin
            tab_cx(b, a);
            tab_cx(a, b);
            tab_cx(b, a);
          end
        endcase
      end
    end else if (op <= ctgu_pkg::OP_V) begin
      if (a < NUM_Q) begin
        case (op)
          ctgu_pkg::OP_X:   tab_sign ^= tab_z[a];
          ctgu_pkg::OP_Z:   tab_sign ^= tab_x[a];
          ctgu_pkg::OP_S:   tab_s(a);
          ctgu_pkg::OP_SDG: repeat (SDG_TURNS) tab_s(a);
          ctgu_pkg::OP_H:   tab_h(a);
          default:          tab_v(a);
        endcase
      end
    end else if (op == ctgu_pkg::OP_READ) begin
      if (col < 2 * NUM_Q) begin
        for (int i = 0; i < NUM_Q && i < ctgu_pkg::RD_W; i++) begin
          res.z_col[i] = tab_z[i][col];
          res.x_col[i] = tab_x[i][col];
        end
        res.sign = tab_sign[col];
      end
    end
  endtask

  // Offer one request, wait for the handshake, then record its prediction.
  task automatic send_request(input logic [ctgu_pkg::OP_W-1:0] op,
                              input logic [ctgu_pkg::QUBIT_W-1:0] a,
                              input logic [ctgu_pkg::QUBIT_W-1:0] b,
                              input logic [ctgu_pkg::COLUMN_W-1:0] col);
    int unsigned    gap;
    column_result_t res;
    gap = 0;
    if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, col, b, a};
    in_tuser  <= op;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    predict_column(op, a, b, col, res);
    column_q = {column_q, res};
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (column_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(output logic [ctgu_pkg::OP_W-1:0] op,
                                output logic [ctgu_pkg::QUBIT_W-1:0] a,
                                output logic [ctgu_pkg::QUBIT_W-1:0] b,
                                output logic [ctgu_pkg::COLUMN_W-1:0] col);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    a    = 4'($urandom_range(0, NUM_Q - 1));
    b    = 4'($urandom_range(0, NUM_Q - 1));
    col  = 5'($urandom_range(0, 2 * NUM_Q - 1));
    if (pick < 55) begin
      op = 4'($urandom_range(ctgu_pkg::OP_X, ctgu_pkg::OP_V));
    end else if (pick < 75) begin
      op = 4'($urandom_range(ctgu_pkg::OP_CX, ctgu_pkg::OP_SWAP));
      // keep most two-qubit gates legal so the tableau keeps moving
      if ($urandom_range(0, 9) != 0)
        while (b == a) b = 4'($urandom_range(0, NUM_Q - 1));
    end else if (pick < 96) begin
      op = ctgu_pkg::OP_READ;
    end else begin
      op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Sample between edges; what is seen here is what the next edge accepts.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (column_q.size() == 0) begin
        $error("result with no request waiting: tdata %h tuser %h", out_tdata, out_tuser);
        failures++;
      end else begin
        oldest_column = column_q.pop_front();
        if (out_tdata[15:0] !== oldest_column.z_col) begin
          $error("z_column: expected %h, actual %h", oldest_column.z_col, out_tdata[15:0]);
          failures++;
        end
        if (out_tdata[31:16] !== oldest_column.x_col) begin
          $error("x_column: expected %h, actual %h", oldest_column.x_col, out_tdata[31:16]);
          failures++;
        end
        if (out_tdata[32] !== oldest_column.sign) begin
          $error("column sign: expected %b, actual %b", oldest_column.sign, out_tdata[32]);
          failures++;
        end
        if (out_tuser[0] !== oldest_column.err) begin
          $error("error: expected %b, actual %b", oldest_column.err, out_tuser[0]);
          failures++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_READ, 4'd15, 4'd15, 5'd7);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd15, 5'd15);
    send_request(ctgu_pkg::OP_READ, 4'd15, 4'd0, 5'd16);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd31);
  endtask

  task automatic test_one_qubit_gates();
    send_request(ctgu_pkg::OP_X, 4'd0, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_Z, 4'd15, 4'd0, 5'd31);
    send_request(ctgu_pkg::OP_S, 4'd3, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_SDG, 4'd3, 4'd15, 5'd0);
    send_request(ctgu_pkg::OP_H, 4'd9, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_V, 4'd9, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd9);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd25);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd19);
  endtask

  task automatic test_two_qubit_gates();
    send_request(ctgu_pkg::OP_CX, 4'd0, 4'd15, 5'd0);
    send_request(ctgu_pkg::OP_CZ, 4'd15, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_SWAP, 4'd3, 4'd12, 5'd0);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd0);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd31);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd12);
  endtask

  task automatic test_special_cases();
    // equal qubits flag an error and leave the tableau alone
    send_request(ctgu_pkg::OP_CX, 4'd5, 4'd5, 5'd0);
    send_request(ctgu_pkg::OP_CZ, 4'd15, 4'd15, 5'd31);
    send_request(ctgu_pkg::OP_SWAP, 4'd0, 4'd0, 5'd0);
    // spare opcodes do nothing
    send_request(OP_SPARE_FIRST, 4'd1, 4'd2, 5'd3);
    send_request(OP_SPARE_LAST, 4'd15, 4'd15, 5'd31);
    send_request(ctgu_pkg::OP_READ, 4'd0, 4'd0, 5'd15);
  endtask

  task automatic test_backpressure();
    logic [ctgu_pkg::OP_W-1:0]     op;
    logic [ctgu_pkg::QUBIT_W-1:0]  a;
    logic [ctgu_pkg::QUBIT_W-1:0]  b;
    logic [ctgu_pkg::COLUMN_W-1:0] col;
    idling_on    = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      random_request(op, a, b, col);
      send_request(op, a, b, col);
    end
    wait_for_drain();
  endtask

  task automatic test_random(input int unsigned count, input bit with_idling);
    logic [ctgu_pkg::OP_W-1:0]     op;
    logic [ctgu_pkg::QUBIT_W-1:0]  a;
    logic [ctgu_pkg::QUBIT_W-1:0]  b;
    logic [ctgu_pkg::COLUMN_W-1:0] col;
    idling_on = with_idling;
    repeat (count) begin
      random_request(op, a, b, col);
      send_request(op, a, b, col);
    end
  endtask

  initial begin
    tab_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_one_qubit_gates();
    test_two_qubit_gates();
    test_special_cases();
    test_backpressure();
    test_random(650, 1'b1);
    test_random(230, 1'b0);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[clifford_tableau_gate_update] OK");
    end else begin
      $display("[clifford_tableau_gate_update] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ctgu_pkg.sv
rtl/clifford_tableau_gate_update.sv
bench/clifford_tableau_gate_update_tb.sv
